// ===== sv/wbe_pkg.sv =====
// shared types, constants and functions of the base58check key encoder
`default_nettype none
package wbe_pkg;
    localparam int KEY_BYTES_DEF = 32;
    localparam int MAX_CHARS     = 51;
    localparam logic [7:0] VERSION_RESET = 8'h80;
    localparam logic [6:0] CHAR_ONE = 7'd49;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD1, ST_SHA1, ST_FOLD1, ST_LOAD2, ST_SHA2, ST_FOLD2,
        ST_ZERO, ST_DIV, ST_DIGIT, ST_EMIT
    } t_state;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[i];
    endfunction

    function automatic logic [6:0] alphabet(input logic [5:0] d);
        logic [6:0] a [58];
        a = '{
        7'd49,7'd50,7'd51,7'd52,7'd53,7'd54,7'd55,7'd56,7'd57,7'd65,7'd66,7'd67,7'd68,
        7'd69,7'd70,7'd71,7'd72,7'd74,7'd75,7'd76,7'd77,7'd78,7'd80,7'd81,7'd82,7'd83,
        7'd84,7'd85,7'd86,7'd87,7'd88,7'd89,7'd90,7'd97,7'd98,7'd99,7'd100,7'd101,7'd102,
        7'd103,7'd104,7'd105,7'd106,7'd107,7'd109,7'd110,7'd111,7'd112,7'd113,7'd114,
        7'd115,7'd116,7'd117,7'd118,7'd119,7'd120,7'd121,7'd122};
        return (d < 6'd58) ? a[d] : CHAR_ONE;
    endfunction
endpackage
`default_nettype wire

// ===== sv/wbe_sha_round.sv =====
// sha-256 compression core: one round per cycle with a rolling message schedule
`default_nettype none
module wbe_sha_round (
    input  wire logic         i_clk,
    input  wire logic         i_start,
    input  wire logic [511:0] i_block,
    output logic [255:0]      o_digest,
    output logic              o_done
);
    import wbe_pkg::*;
    localparam logic [255:0] H_INIT = {32'h6a09e667,32'hbb67ae85,32'h3c6ef372,
        32'ha54ff53a,32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

    logic [511:0] r_w;
    logic [31:0]  r_v [8];
    logic [5:0]   r_rnd;
    logic         r_busy, r_done;
    logic [31:0]  t1, t2, w0, s0, s1, wn;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb begin
        w0 = r_w[511:480];
        s0 = rotr(r_w[479:448], 7) ^ rotr(r_w[479:448], 18) ^ (r_w[479:448] >> 3);
        s1 = rotr(r_w[63:32], 17) ^ rotr(r_w[63:32], 19) ^ (r_w[63:32] >> 10);
        wn = w0 + s0 + r_w[223:192] + s1;
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(r_rnd) + w0;
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        for (int i = 0; i < 8; i++) begin
            o_digest[255-32*i -: 32] = H_INIT[255-32*i -: 32] + r_v[i];
        end
    end
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (i_start) begin
            r_w   <= i_block;
            r_rnd <= '0;
            r_busy <= 1'b1;
            for (int i = 0; i < 8; i++) r_v[i] <= H_INIT[255-32*i -: 32];
        end else if (r_busy) begin
            r_w <= {r_w[479:0], wn};
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            r_rnd <= r_rnd + 6'd1;
            if (r_rnd == 6'd63) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/wbe_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module wbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== sv/wif_base58check_encoder.sv =====
// top level: key to base58check string encoder
// usage:
//   input beat: four 64-bit key words, key_word0 most significant; taken on
//   i_valid && o_ready. o_ready is low from the accepted key until its last
//   character has been taken, so one key is in flight at a time.
//   output beats: one base58 character per beat, o_last on the final one.
//   config: i_cfg_valid/o_cfg_ready writes the version byte (reset 0x80),
//   always ready; write it only while idle.
// sequence: two sha compressions, each a block load and then the rounds, then a
//   checksum fold and a zero byte check over KEY_BYTES+5 bytes; then for each
//   base58 digit a long division over every byte in the byte-serial
//   divide-by-58 unit and a digit store; then the leading '1's and the digit
//   characters, each digit a ram read and then a load.
// the sha core runs one round a cycle; digits are kept in a small ram and
//   read back most significant first.
// reset: sequencer to idle, version byte to 0x80, no output pending.
// stall: a held character waits in the output register; the sequencer
//   pauses until the receiver takes it.
`default_nettype none
module wif_base58check_encoder #(
    parameter int KEY_BYTES = wbe_pkg::KEY_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_key_word0,
    input  wire logic [63:0] i_key_word1,
    input  wire logic [63:0] i_key_word2,
    input  wire logic [63:0] i_key_word3,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [6:0]       o_char_code,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_version_byte
);
    import wbe_pkg::*;
    localparam int TOTAL = KEY_BYTES + 5;
    localparam int MLEN  = KEY_BYTES + 1;
    localparam int NB    = 8 * TOTAL;
    localparam int BW    = $clog2(TOTAL + 1);
    localparam int DW    = $clog2(MAX_CHARS + 1);
    localparam logic [63:0] MBITS1 = 64'(8 * MLEN);

    t_state r_state, n_state;
    logic [7:0]    r_ver;
    logic [NB-1:0] r_num;       // payload and then running quotient
    logic [255:0]  r_hash;
    logic [511:0]  sha_blk;
    logic          sha_start, sha_done;
    logic [255:0]  sha_dig;
    logic [BW-1:0] r_idx;       // byte index during scans
    logic [BW-1:0] r_zeros;
    logic          r_zscan;     // still in the leading zero run
    logic [5:0]    r_rem;
    logic          r_nz;
    logic [DW-1:0] r_ndig;      // digits stored
    logic [DW-1:0] r_nout;      // zero ones left to emit
    logic          r_out_v, r_out_l;
    logic [6:0]    r_out_c;
    logic          r_rd_pend;
    logic [13:0]   cur;
    logic [7:0]    qbyte;
    logic [5:0]    nrem;
    logic [7:0]    nbyte;
    logic          ram_we;
    logic [DW-1:0] ram_addr;
    logic [5:0]    ram_q;
    logic          out_free;
    logic          emit_now;
    logic [255:0]  key;

    assign key = {i_key_word0, i_key_word1, i_key_word2, i_key_word3};
    assign out_free = !r_out_v || i_ready;
    assign o_ready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid = r_out_v;
    assign o_char_code = r_out_c;
    assign o_last = r_out_l;

    // a character is loaded this cycle: a leading '1' or a digit just read
    assign emit_now = (r_state == ST_EMIT) && out_free && (r_rd_pend || r_nout != '0);

    // padded sha blocks: first over version+key, second over the 32-byte digest
    always_comb begin
        sha_blk = '0;
        if (r_state == ST_LOAD1) begin
            sha_blk[511 -: 8*MLEN] = r_num[NB-1 -: 8*MLEN];
            sha_blk[511-8*MLEN -: 8] = 8'h80;
            sha_blk[63:0] = MBITS1;
        end else begin
            sha_blk[511:256] = r_hash;
            sha_blk[255:248] = 8'h80;
            sha_blk[63:0] = 64'd256;
        end
    end
    assign sha_start = (r_state == ST_LOAD1) || (r_state == ST_LOAD2);

    wbe_sha_round u_sha (
        .i_clk(i_clk), .i_start(sha_start), .i_block(sha_blk),
        .o_digest(sha_dig), .o_done(sha_done)
    );

    // byte-serial divide by 58: the top byte of r_num each step
    always_comb begin
        nbyte = r_num[NB-1 -: 8];
        cur   = {r_rem, nbyte};
        qbyte = 8'((23'(cur) * 23'd565) >> 15);
        if (14'(cur - 14'(qbyte) * 14'd58) >= 14'd58) qbyte = qbyte + 8'd1;
        nrem  = 6'(cur - 14'(qbyte) * 14'd58);
    end

    assign ram_we   = (r_state == ST_DIGIT);
    assign ram_addr = ram_we ? r_ndig : DW'(r_ndig - DW'(1));

    wbe_ram #(.WIDTH(6), .DEPTH(1 << DW)) u_dig (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr), .i_wdata(r_rem),
        .o_rdata(ram_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_LOAD1;
            ST_LOAD1: n_state = ST_SHA1;
            ST_SHA1:  if (sha_done) n_state = ST_LOAD2;
            ST_FOLD1: n_state = ST_LOAD2;
            ST_LOAD2: n_state = ST_SHA2;
            ST_SHA2:  if (sha_done) n_state = ST_FOLD2;
            ST_FOLD2: n_state = ST_ZERO;
            ST_ZERO:  if (r_idx == BW'(TOTAL - 1)) n_state = ST_DIV;
            ST_DIV:   if (r_idx == BW'(TOTAL - 1)) n_state = ST_DIGIT;
            ST_DIGIT: n_state = r_nz ? ST_DIV : ST_EMIT;
            ST_EMIT:  if (out_free && r_nout == '0 && r_ndig == '0 && !r_rd_pend)
                          n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ver   <= VERSION_RESET;
            r_out_v <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_ver <= i_cfg_version_byte;
            if (out_free) r_out_v <= emit_now;
            unique case (r_state)
                ST_IDLE: if (i_valid) begin
                    r_num <= {r_ver, key[255 -: 8*KEY_BYTES], 32'd0};
                end
                ST_SHA1: if (sha_done) r_hash <= sha_dig;
                ST_FOLD2: begin
                    r_num[31:0] <= sha_dig[255:224];
                    r_idx <= '0; r_zeros <= '0; r_zscan <= 1'b1;
                end
                ST_ZERO: begin
                    r_num <= {r_num[NB-9:0], nbyte};
                    if (r_zscan && nbyte == 8'd0) r_zeros <= r_zeros + BW'(1);
                    else r_zscan <= 1'b0;
                    r_idx <= (r_idx == BW'(TOTAL - 1)) ? '0 : r_idx + BW'(1);
                    r_rem <= '0; r_nz <= 1'b0; r_ndig <= '0;
                end
                ST_DIV: begin
                    r_num <= {r_num[NB-9:0], qbyte};
                    r_rem <= nrem;
                    if (qbyte != 8'd0) r_nz <= 1'b1;
                    r_idx <= (r_idx == BW'(TOTAL - 1)) ? '0 : r_idx + BW'(1);
                end
                ST_DIGIT: begin
                    r_rem <= '0; r_nz <= 1'b0;
                    if (!r_nz) begin
                        r_nout <= DW'(r_zeros);
                        if (r_zeros == BW'(TOTAL)) r_ndig <= '0;
                        else r_ndig <= r_ndig + DW'(1);
                    end else begin
                        r_ndig <= r_ndig + DW'(1);
                    end
                end
                ST_EMIT: begin
                    if (out_free && !r_rd_pend) begin
                        if (r_nout != '0) begin
                            r_out_c <= CHAR_ONE;
                            r_out_l <= (r_nout == DW'(1)) && (r_ndig == '0);
                            r_nout  <= r_nout - DW'(1);
                        end else if (r_ndig != '0) begin
                            r_rd_pend <= 1'b1;
                            r_ndig <= r_ndig - DW'(1);
                        end
                    end else if (r_rd_pend && out_free) begin
                        r_rd_pend <= 1'b0;
                        r_out_c <= alphabet(ram_q);
                        r_out_l <= (r_ndig == '0);
                    end
                end
                default: ;
            endcase
        end
    end

    // the hash digest only matters after the first compression finishes
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !r_out_v || r_out_l) else $error("ready with string open");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !i_ready |=> r_out_v && $stable(r_out_c)) else $error("char lost");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> !o_ready) else $error("ready while dividing");
endmodule
`default_nettype wire
